// ===== rtl/core/adts_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ADTS deframer: sync constants, parser phase codes and
// the result record passed from the parser to the output register. No dependencies.
package adts_pkg;

  localparam logic [7:0] SYNC_OCTET    = 8'hFF;
  localparam logic [7:0] SYNC2_MASK    = 8'hF6;
  localparam logic [7:0] SYNC2_VALUE   = 8'hF0;
  localparam logic [7:0] PROT_ABS_MASK = 8'h01;
  localparam logic [7:0] LEN_HI_MASK   = 8'h03;
  localparam logic [7:0] LEN_LO_MASK   = 8'hE0;

  localparam logic [3:0] HDR_SIZE_PLAIN = 4'd7;
  localparam logic [3:0] HDR_SIZE_CRC   = 4'd9;

  localparam logic [3:0] HDR_IDX_AFTER_SYNC = 4'd2;
  localparam logic [3:0] HDR_IDX_LEN_HI     = 4'd3;
  localparam logic [3:0] HDR_IDX_LEN_MID    = 4'd4;
  localparam logic [3:0] HDR_IDX_LEN_LO     = 4'd5;

  localparam int unsigned MS_W   = 10;
  localparam logic [MS_W-1:0] MS_PER_FRAME_RESET = 10'd23;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_SYNC = 4'b0010,
    PH_HEAD = 4'b0100,
    PH_BODY = 4'b1000
  } adts_phase_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  payload_octet;
    logic        frame_start;
    logic        frame_end;
    logic [31:0] frame_time_ms;
  } adts_result_t;

endpackage

// ===== rtl/core/adts_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the ADTS deframer: raw stream in,
// payload items out. No dependencies.
interface adts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_octet;

  modport source (output valid, output stream_octet, input ready);
  modport sink (input valid, input stream_octet, output ready);
endinterface

interface adts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_octet;
  logic        frame_start;
  logic        frame_end;
  logic [31:0] frame_time_ms;

  modport source (output valid, output payload_octet, output frame_start,
                  output frame_end, output frame_time_ms, input ready);
  modport sink (input valid, input payload_octet, input frame_start,
                input frame_end, input frame_time_ms, output ready);
endinterface

// ===== rtl/core/adts_parser.sv =====
`timescale 1ns / 1ps
// ADTS header parser: holds the framing state and turns one stream octet
// into at most one payload result per step. Depends on adts_pkg.
module adts_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                octet,
  input  logic [adts_pkg::MS_W-1:0] ms_per_frame,
  output adts_pkg::adts_result_t    result
);
  import adts_pkg::*;

  adts_phase_t phase_r, phase_nxt;
  logic [3:0]  hdr_idx_r, hdr_idx_nxt;
  logic [3:0]  hdr_size_r, hdr_size_nxt;
  logic [12:0] frame_size_r, frame_size_nxt;
  logic [12:0] bytes_rem_r, bytes_rem_nxt;
  logic [31:0] time_r, time_nxt;
  logic        first_r, first_nxt;

  logic [4:0]  idx_inc;
  logic        last;

  always_comb begin
    phase_nxt      = phase_r;
    hdr_idx_nxt    = hdr_idx_r;
    hdr_size_nxt   = hdr_size_r;
    frame_size_nxt = frame_size_r;
    bytes_rem_nxt  = bytes_rem_r;
    time_nxt       = time_r;
    first_nxt      = first_r;
    idx_inc        = {1'b0, hdr_idx_r} + 5'd1;
    last           = (bytes_rem_r <= 13'd1);
    result         = '0;
    result.payload_octet = octet;
    result.frame_start   = first_r;
    result.frame_end     = last;
    result.frame_time_ms = time_r;

    case (phase_r)
      PH_HUNT: begin
        if (octet == SYNC_OCTET) begin
          phase_nxt   = PH_SYNC;
          hdr_idx_nxt = 4'd1;
        end
      end
      PH_SYNC: begin
        if ((octet & SYNC2_MASK) == SYNC2_VALUE) begin
          hdr_size_nxt   = ((octet & PROT_ABS_MASK) != 8'd0) ? HDR_SIZE_PLAIN : HDR_SIZE_CRC;
          hdr_idx_nxt    = HDR_IDX_AFTER_SYNC;
          frame_size_nxt = '0;
          phase_nxt      = PH_HEAD;
        end else if (octet != SYNC_OCTET) begin
          phase_nxt   = PH_HUNT;
          hdr_idx_nxt = '0;
        end
      end
      PH_HEAD: begin
        case (hdr_idx_r)
          HDR_IDX_LEN_HI:  frame_size_nxt[12:11] = octet[1:0];
          HDR_IDX_LEN_MID: frame_size_nxt[10:3]  = octet;
          HDR_IDX_LEN_LO:  frame_size_nxt[2:0]   = octet[7:5];
          default: ;
        endcase
        // The header is complete once its last octet has been taken.
        if (idx_inc >= {1'b0, hdr_size_r}) begin
          hdr_idx_nxt = '0;
          if (frame_size_nxt > {9'd0, hdr_size_r}) begin
            bytes_rem_nxt = frame_size_nxt - {9'd0, hdr_size_r};
            first_nxt     = 1'b1;
            phase_nxt     = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end else begin
          hdr_idx_nxt = idx_inc[3:0];
        end
      end
      PH_BODY: begin
        result.emit = 1'b1;
        first_nxt   = 1'b0;
        if (last) begin
          bytes_rem_nxt = '0;
          time_nxt      = time_r + {22'd0, ms_per_frame};
          phase_nxt     = PH_HUNT;
        end else begin
          bytes_rem_nxt = bytes_rem_r - 13'd1;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      hdr_idx_r    <= '0;
      hdr_size_r   <= HDR_SIZE_PLAIN;
      frame_size_r <= '0;
      bytes_rem_r  <= '0;
      time_r       <= '0;
      first_r      <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      hdr_size_r   <= hdr_size_nxt;
      frame_size_r <= frame_size_nxt;
      bytes_rem_r  <= bytes_rem_nxt;
      time_r       <= time_nxt;
      first_r      <= first_nxt;
    end
  end

endmodule

// ===== rtl/core/adts_frame_deframer.sv =====
`timescale 1ns / 1ps
// ADTS deframer top level: input register, header parser, output register.
// An accepted octet passes the input register, the parser and the output
// register. Throughput: one octet per cycle unless out_ch stalls.
// Reset (rst_n, synchronous, active low) returns the parser to hunting for
// sync, empties both pipeline registers and restores ms_per_frame to 23.
// Depends on adts_pkg, adts_if and adts_parser.
module adts_frame_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  adts_in_if.sink                   in_ch,
  adts_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  logic [adts_pkg::MS_W-1:0] cfg_wdata
);
  import adts_pkg::*;

  logic [MS_W-1:0] ms_per_frame_r;
  logic            in_vld_r;
  logic [7:0]      in_octet_r;
  logic            out_vld_r;
  adts_result_t    out_r;
  adts_result_t    result;
  logic            advance;

  // The parser steps when an octet waits and out_r can take the result.
  assign advance      = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_per_frame_r <= MS_PER_FRAME_RESET;
    end else if (cfg_we) begin
      ms_per_frame_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_octet_r <= in_ch.stream_octet;
    end
  end

  adts_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .octet        (in_octet_r),
    .ms_per_frame (ms_per_frame_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= result.emit;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.payload_octet = out_r.payload_octet;
  assign out_ch.frame_start   = out_r.frame_start;
  assign out_ch.frame_end     = out_r.frame_end;
  assign out_ch.frame_time_ms = out_r.frame_time_ms;

endmodule
